>>> rtl/bba_pkg.sv
// Shared types and codes of the block bitmap allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bba_pkg;

   localparam int DEFAULT_MAX_BLOCKS = 1024;

   // Widths fixed by the request and result fields
   localparam int CNT_W    = 11;   // block_count, free_count, used counter
   localparam int BLK_W    = 16;   // absolute block numbers
   localparam int KIND_W   = 2;    // request kind and status
   localparam int WORD_W   = 32;   // bits per map word
   localparam int BIT_W    = 5;    // bit select inside a map word
   localparam int WADDR_W  = CNT_W - BIT_W;   // word address, largest map
   localparam int CNT_MAX  = (1 << CNT_W) - 1;

   // Request kinds
   localparam logic [KIND_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd2;

   // Result status
   localparam logic [KIND_W-1:0] STS_OK    = 2'd0;
   localparam logic [KIND_W-1:0] STS_FULL  = 2'd1;
   localparam logic [KIND_W-1:0] STS_RANGE = 2'd2;

   // Register indexes
   localparam logic CSR_DATA_START  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   // Access of the sequencer to the map store
   typedef struct packed {
      logic               clr;
      logic               wr_en;
      logic [WADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]  wr_data;
      logic [WADDR_W-1:0] rd_addr;
   } map_ctl_type;

endpackage

`default_nettype wire

>>> rtl/bba_map.sv
// Free map store: one bit per block in 32-bit words, registered read.
// A valid bit per word makes reset and clear take effect at once.
// Depends on bba_pkg.
`default_nettype none

module bba_map #(
   parameter int WORDS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bba_pkg::map_ctl_type       ctl,
   output logic [bba_pkg::WORD_W-1:0]      rd_data
);
   import bba_pkg::*;

   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [WORD_W-1:0] map_mem [WORDS];
   logic [WORDS-1:0]  valid_ff;
   logic [WORD_W-1:0] rd_q_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         map_mem[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
      end
      rd_q_ff <= map_mem[ctl.rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.clr) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[ctl.wr_addr[AW-1:0]] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[ctl.rd_addr[AW-1:0]];
      end
   end

   // A word never written since the last clear reads as all free
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

>>> rtl/block_bitmap_allocator_core.sv
// First-fit bitmap block allocator: top level, sequencer and map store.
// Depends on bba_pkg and bba_map.
//
// Usage:
//   req channel: one word per request. req_tuser is the request kind
//   (allocate, free, clear), req_tdata the block number to free.
//   rsp channel: one word per request with status in rsp_tuser and the
//   granted block and free count in rsp_tdata.
//   csr port: index 0 data_start, index 1 block_count; write only while idle.
// Operation:
//   allocate walks the map one 32-bit word per cycle through a single
//   priority encoder and stops at the first word with a free bit. Free
//   reads the word, then checks and writes it back, then loads the result.
//   Clear and out-of-range requests go straight to the result. One request
//   is in flight at a time; req_tready is high only while the sequencer is
//   idle.
// Reset: the map reads all free at once (per-word valid bits), the used
//   counter is zero, data_start is 0 and block_count is 1024.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile and its result holds until the output register empties.
`default_nettype none

module block_bitmap_allocator_core #(
   parameter int MAX_BLOCKS = bba_pkg::DEFAULT_MAX_BLOCKS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [bba_pkg::BLK_W-1:0]   csr_wdata,
   // requests
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [15:0]                 req_tdata,   // [15:0] block_number
   input  wire logic [1:0]                  req_tuser,   // [1:0] req_type
   // results
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [31:0]                      rsp_tdata,   // [15:0] allocated_block,
                                                         // [26:16] free_count, zero above
   output logic [1:0]                       rsp_tuser    // [1:0] status
);
   import bba_pkg::*;

   localparam int MAP_BLOCKS = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
   localparam int WORDS      = (MAP_BLOCKS + WORD_W - 1) / WORD_W;
   localparam logic [CNT_W-1:0] MAP_LIMIT = CNT_W'(MAP_BLOCKS);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_SCAN     = 5'b00010,
      S_FREE_CHK = 5'b00100,
      S_RESP     = 5'b01000,
      S_SPARE    = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [BLK_W-1:0]   data_start_ff;
   logic [CNT_W-1:0]   block_count_ff;
   logic [CNT_W-1:0]   used_total_ff, used_total_in;
   logic [WADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [WADDR_W-1:0] chk_addr_ff, chk_addr_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               issue_done_ff, issue_done_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [KIND_W-1:0]  res_status_ff, res_status_in;
   logic [BLK_W-1:0]   res_block_ff, res_block_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_status_ff;
   logic [BLK_W-1:0]   rsp_block_ff;
   logic [CNT_W-1:0]   rsp_free_ff;
   logic               rsp_load;

   logic [CNT_W-1:0]   n_eff;
   logic [WADDR_W-1:0] last_word;
   logic [CNT_W-1:0]   free_now;
   logic [BLK_W:0]     free_diff;
   logic               in_range;
   logic [WORD_W-1:0]  rd_data;
   logic [WORD_W-1:0]  allow_mask;
   logic [WORD_W-1:0]  cand;
   logic               found;
   logic [BIT_W-1:0]   hit_bit;
   map_ctl_type        map_ctl;

   // ---------------------------------------------------------------
   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff  <= '0;
         block_count_ff <= CNT_W'(1024);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DATA_START:  data_start_ff  <= csr_wdata;
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign n_eff     = (block_count_ff > MAP_LIMIT) ? MAP_LIMIT : block_count_ff;
   assign last_word = WADDR_W'((n_eff - CNT_W'(1)) >> BIT_W);
   assign free_now  = (used_total_ff >= n_eff) ? '0 : (n_eff - used_total_ff);

   // Range check of a free request, straight from the port
   assign free_diff = {1'b0, req_tdata} - {1'b0, data_start_ff};
   assign in_range  = !free_diff[BLK_W] && (free_diff[BLK_W-1:0] < {5'b0, n_eff});

   // ---------------------------------------------------------------
   // Word unit of the scan: mask off bits past the block count, pick the
   // lowest free bit of the word under check
   always_comb begin
      if ((chk_addr_ff == last_word) && (n_eff[BIT_W-1:0] != '0)) begin
         allow_mask = (WORD_W'(1) << n_eff[BIT_W-1:0]) - WORD_W'(1);
      end else begin
         allow_mask = '1;
      end
   end

   assign cand  = ~rd_data & allow_mask;
   assign found = |cand;

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) hit_bit = BIT_W'(b);
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   always_comb begin
      state_in      = state_ff;
      used_total_in = used_total_ff;
      scan_addr_in  = scan_addr_ff;
      chk_addr_in   = chk_addr_ff;
      chk_vld_in    = 1'b0;
      issue_done_in = issue_done_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      map_ctl       = '0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            idx_in          = free_diff[CNT_W-1:0];
            map_ctl.rd_addr = free_diff[CNT_W-1:BIT_W];
            res_block_in    = '0;
            res_status_in   = STS_OK;
            if (req_tvalid) begin
               case (req_tuser)
                  REQ_ALLOC: begin
                     if (n_eff == '0) begin
                        res_status_in = STS_FULL;
                        state_in      = S_RESP;
                     end else begin
                        scan_addr_in  = '0;
                        issue_done_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  REQ_FREE: begin
                     if (in_range) begin
                        state_in = S_FREE_CHK;
                     end else begin
                        res_status_in = STS_RANGE;
                        state_in      = S_RESP;
                     end
                  end
                  REQ_CLEAR: begin
                     map_ctl.clr   = 1'b1;
                     used_total_in = '0;
                     state_in      = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_SCAN: begin
            // issue one word read per cycle, check the word read last cycle
            map_ctl.rd_addr = scan_addr_ff;
            chk_addr_in     = scan_addr_ff;
            chk_vld_in      = !issue_done_ff;
            if (!issue_done_ff) begin
               if (scan_addr_ff == last_word) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + WADDR_W'(1);
               end
            end
            if (chk_vld_ff) begin
               if (found) begin
                  map_ctl.wr_en   = 1'b1;
                  map_ctl.wr_addr = chk_addr_ff;
                  map_ctl.wr_data = rd_data | (WORD_W'(1) << hit_bit);
                  used_total_in   = used_total_ff + CNT_W'(1);
                  res_block_in    = data_start_ff + BLK_W'({chk_addr_ff, hit_bit});
                  res_status_in   = STS_OK;
                  state_in        = S_RESP;
               end else if (chk_addr_ff == last_word) begin
                  res_status_in = STS_FULL;
                  state_in      = S_RESP;
               end
            end
         end

         S_FREE_CHK: begin
            map_ctl.rd_addr = idx_ff[CNT_W-1:BIT_W];
            if (rd_data[idx_ff[BIT_W-1:0]]) begin
               map_ctl.wr_en   = 1'b1;
               map_ctl.wr_addr = idx_ff[CNT_W-1:BIT_W];
               map_ctl.wr_data = rd_data & ~(WORD_W'(1) << idx_ff[BIT_W-1:0]);
               if (used_total_ff != '0) used_total_in = used_total_ff - CNT_W'(1);
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_total_ff <= '0;
         chk_vld_ff    <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_total_ff <= used_total_in;
         chk_vld_ff    <= chk_vld_in;
         issue_done_ff <= issue_done_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      chk_addr_ff   <= chk_addr_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
   end

   // ---------------------------------------------------------------
   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
         rsp_free_ff   <= free_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_free_ff, rsp_block_ff};

   // ---------------------------------------------------------------
   bba_map #(
      .WORDS (WORDS)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .ctl     (map_ctl),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

>>> rtl/bba_sva_chk.sv
// Port-level checks of the block bitmap allocator, bound to the top level.
// Depends on bba_pkg.
`default_nettype none

module bba_sva_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   import bba_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // one request at a time: busy after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a failed request grants no block
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STS_FULL || rsp_tuser == STS_RANGE)
      |-> rsp_tdata[15:0] == '0)
      else $error("block granted on a failed request");

   // a full map leaves nothing free
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_FULL |-> rsp_tdata[26:16] == '0)
      else $error("map full with free blocks left");

endmodule

bind block_bitmap_allocator_core bba_sva_chk u_bba_sva_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
